>>> hw/rtl/rdt_pkg.sv
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared widths, register map, reset values and controller/datapath
// command and status types for the rational duration to ticks core.
// ----------------------------------------------------------------------------
package rdt_pkg;

    // Field widths
    localparam int LEN_W    = 16;               // length_num / length_den
    localparam int EXTRA_W  = 16;               // extra_ticks
    localparam int TPU_W    = 15;               // ticks_per_unit
    localparam int PROD_W   = TPU_W + LEN_W;    // ticks_per_unit * length_num
    localparam int TICKS_W  = 32;               // ticks result
    localparam int SUM_W    = TICKS_W + 1;      // unsaturated ticks sum

    // Stored remainder width default
    localparam int REM_W_DEF = 32;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_UNIT = REG_IDX_W'(0);

    localparam logic [TPU_W-1:0]   TPU_RESET = TPU_W'(480);
    localparam logic [TICKS_W-1:0] TICKS_MAX = {1'b0, {(TICKS_W-1){1'b1}}};

    // Controller to datapath
    typedef struct packed {
        logic load_in;     // capture input transfer, load quotient divider
        logic div_step;    // advance shared divider by one bit
        logic frac_load;   // capture whole/frac, clear product accumulators
        logic mul_step;    // advance bit-serial products by one bit
        logic cmp_load;    // take carry out of sum, seed gcd
        logic gcd_step;    // one binary gcd step
        logic div2_load;   // load reduction divider
        logic commit;      // write result register and remainder
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic den_zero;    // incoming denominator is zero
        logic gcd_done;    // gcd search finished
    } t_status;

endpackage

>>> hw/rtl/rdt_div.sv
// ----------------------------------------------------------------------------
// rdt_div
// Two-lane restoring divider, one quotient bit per step, shared divisor.
// The dividend register collects the quotient as it shifts out.
// ----------------------------------------------------------------------------
module rdt_div #(
    parameter int XW = 48
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_step,
    input  logic [XW-1:0] i_dvd_a,
    input  logic [XW-1:0] i_dvd_b,
    input  logic [XW-1:0] i_dvs,
    output logic [XW-1:0] o_quo_a,
    output logic [XW-1:0] o_quo_b,
    output logic [XW-1:0] o_rem_a
);
    logic [XW-1:0] r_dvd_a, r_dvd_b, r_rem_a, r_rem_b, r_dvs;
    logic [XW:0]   w_ta, w_tb, w_dif_a, w_dif_b;
    logic          w_ge_a, w_ge_b;

    assign w_ta    = {r_rem_a, r_dvd_a[XW-1]};
    assign w_tb    = {r_rem_b, r_dvd_b[XW-1]};
    assign w_ge_a  = w_ta >= {1'b0, r_dvs};
    assign w_ge_b  = w_tb >= {1'b0, r_dvs};
    assign w_dif_a = w_ta - {1'b0, r_dvs};
    assign w_dif_b = w_tb - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd_a <= i_dvd_a;
            r_dvd_b <= i_dvd_b;
            r_dvs   <= i_dvs;
            r_rem_a <= '0;
            r_rem_b <= '0;
        end else if (i_step) begin
            r_dvd_a <= {r_dvd_a[XW-2:0], w_ge_a};
            r_dvd_b <= {r_dvd_b[XW-2:0], w_ge_b};
            r_rem_a <= w_ge_a ? w_dif_a[XW-1:0] : w_ta[XW-1:0];
            r_rem_b <= w_ge_b ? w_dif_b[XW-1:0] : w_tb[XW-1:0];
        end
    end

    assign o_quo_a = r_dvd_a;
    assign o_quo_b = r_dvd_b;
    assign o_rem_a = r_rem_a;

endmodule

>>> hw/rtl/rdt_datapath.sv
// ----------------------------------------------------------------------------
// rdt_datapath
// Remainder state, scaled quotient, bit-serial cross products, binary gcd,
// reduction division and saturated ticks result.
// ----------------------------------------------------------------------------
module rdt_datapath #(
    parameter int REM_W = rdt_pkg::REM_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rdt_pkg::t_cmd                i_cmd,
    output rdt_pkg::t_status             o_status,
    input  logic [rdt_pkg::TPU_W-1:0]    i_tpu,
    input  logic [rdt_pkg::LEN_W-1:0]    i_length_num,
    input  logic [rdt_pkg::LEN_W-1:0]    i_length_den,
    input  logic [rdt_pkg::EXTRA_W-1:0]  i_extra_ticks,
    output logic [rdt_pkg::TICKS_W-1:0]  o_ticks,
    output logic                         o_overflow
);
    import rdt_pkg::*;

    localparam int XW = REM_W + LEN_W;   // denominator product / gcd width
    localparam int NW = XW + 1;          // numerator sum width

    // Input capture
    logic [LEN_W-1:0]   r_den;
    logic [EXTRA_W-1:0] r_extra;
    logic               r_skip;

    // Remainder state
    logic [REM_W-1:0]   r_rem_num, r_rem_den;

    // Working registers
    logic [PROD_W-1:0]  r_whole;
    logic [LEN_W-1:0]   r_mb, r_mf;
    logic [NW-1:0]      r_acc_num;
    logic [XW-1:0]      r_acc_den;
    logic               r_q;
    logic [XW-1:0]      r_gu, r_gv, r_cr, r_cd;

    // Result
    logic [TICKS_W-1:0] r_ticks;
    logic               r_ovf;

    // Divider hookup
    logic [PROD_W-1:0]  w_prod;
    logic [XW-1:0]      w_dvd_a, w_dvd_b, w_dvs;
    logic [XW-1:0]      w_quo_a, w_quo_b, w_rem_a;

    logic [NW-1:0]      n_acc_num, w_den_ext, w_rmu_full;
    logic [XW-1:0]      n_acc_den;
    logic               w_q;
    logic [SUM_W-1:0]   w_sum;
    logic               w_fits;

    assign w_prod  = PROD_W'(i_tpu * i_length_num);
    assign w_dvd_a = i_cmd.load_in ? {w_prod, {(XW-PROD_W){1'b0}}} : r_cd;
    assign w_dvd_b = i_cmd.load_in ? '0 : r_cr;
    assign w_dvs   = i_cmd.load_in ? XW'(i_length_den) : r_gv;

    rdt_div #(.XW(XW)) u_div (
        .i_clk   (i_clk),
        .i_load  (i_cmd.load_in | i_cmd.div2_load),
        .i_step  (i_cmd.div_step),
        .i_dvd_a (w_dvd_a),
        .i_dvd_b (w_dvd_b),
        .i_dvs   (w_dvs),
        .o_quo_a (w_quo_a),
        .o_quo_b (w_quo_b),
        .o_rem_a (w_rem_a)
    );

    // Cross products MSB first: num = n*b + d*frac, den = d*b
    assign n_acc_num = {r_acc_num[NW-2:0], 1'b0}
                     + (r_mb[LEN_W-1] ? NW'(r_rem_num) : '0)
                     + (r_mf[LEN_W-1] ? NW'(r_rem_den) : '0);
    assign n_acc_den = {r_acc_den[XW-2:0], 1'b0}
                     + (r_mb[LEN_W-1] ? XW'(r_rem_den) : '0);

    // Carry is 0 or 1 since the sum of two proper fractions stays below 2
    assign w_den_ext  = {1'b0, r_acc_den};
    assign w_q        = r_acc_num >= w_den_ext;
    assign w_rmu_full = r_acc_num - (w_q ? w_den_ext : '0);

    assign w_sum = {{(SUM_W-EXTRA_W){r_extra[EXTRA_W-1]}}, r_extra}
                 + {{(SUM_W-PROD_W){1'b0}}, r_whole}
                 + SUM_W'(r_q);
    assign w_fits = (w_quo_a[XW-1:REM_W] == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_den   <= i_length_den;
            r_extra <= i_extra_ticks;
            r_skip  <= (i_length_den == '0);
        end
        if (i_cmd.frac_load) begin
            r_whole   <= w_quo_a[PROD_W-1:0];
            r_mf      <= w_rem_a[LEN_W-1:0];
            r_mb      <= r_den;
            r_acc_num <= '0;
            r_acc_den <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc_num <= n_acc_num;
            r_acc_den <= n_acc_den;
            r_mb      <= {r_mb[LEN_W-2:0], 1'b0};
            r_mf      <= {r_mf[LEN_W-2:0], 1'b0};
        end
        if (i_cmd.cmp_load) begin
            r_q  <= w_q;
            r_gu <= w_rmu_full[XW-1:0];
            r_cr <= w_rmu_full[XW-1:0];
            r_gv <= r_acc_den;
            r_cd <= r_acc_den;
        end else if (i_cmd.gcd_step && (r_gu != '0)) begin
            if (!r_gu[0] && !r_gv[0]) begin
                // common factor of two: strip it from the fraction too
                r_gu <= r_gu >> 1;
                r_gv <= r_gv >> 1;
                r_cr <= r_cr >> 1;
                r_cd <= r_cd >> 1;
            end else if (!r_gu[0]) begin
                r_gu <= r_gu >> 1;
            end else if (!r_gv[0]) begin
                r_gv <= r_gv >> 1;
            end else if (r_gu >= r_gv) begin
                r_gu <= (r_gu - r_gv) >> 1;
            end else begin
                r_gv <= (r_gv - r_gu) >> 1;
            end
        end
        if (i_cmd.commit) begin
            if (r_skip) begin
                r_ticks <= {{(TICKS_W-EXTRA_W){r_extra[EXTRA_W-1]}}, r_extra};
                r_ovf   <= 1'b0;
            end else begin
                if (!w_sum[SUM_W-1] && w_sum[SUM_W-2]) begin
                    r_ticks <= TICKS_MAX;
                end else begin
                    r_ticks <= w_sum[TICKS_W-1:0];
                end
                r_ovf <= !w_fits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_num <= '0;
            r_rem_den <= REM_W'(1);
        end else if (i_cmd.commit && !r_skip) begin
            if (w_fits) begin
                r_rem_num <= w_quo_b[REM_W-1:0];
                r_rem_den <= w_quo_a[REM_W-1:0];
            end else begin
                r_rem_num <= '0;
                r_rem_den <= REM_W'(1);
            end
        end
    end

    assign o_status.den_zero = (i_length_den == '0);
    assign o_status.gcd_done = (r_gu == '0);
    assign o_ticks           = r_ticks;
    assign o_overflow        = r_ovf;

endmodule

>>> hw/rtl/rdt_ctrl.sv
// ----------------------------------------------------------------------------
// rdt_ctrl
// Sequencer for one item at a time plus the result register handshake.
// ----------------------------------------------------------------------------
module rdt_ctrl #(
    parameter int REM_W = rdt_pkg::REM_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rdt_pkg::t_cmd    o_cmd,
    input  rdt_pkg::t_status i_status
);
    import rdt_pkg::*;

    localparam int XW = REM_W + LEN_W;
    localparam int CW = $clog2(XW + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV1 = 8'b0000_0010,
        S_FRAC = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_CMP  = 8'b0001_0000,
        S_GCD  = 8'b0010_0000,
        S_DIV2 = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_cnt         = '0;
                    n_state       = i_status.den_zero ? S_DONE : S_DIV1;
                end
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CW'(PROD_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FRAC;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_FRAC: begin
                o_cmd.frac_load = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == CW'(LEN_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_CMP;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_CMP: begin
                o_cmd.cmp_load = 1'b1;
                n_state        = S_GCD;
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd.div2_load = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV2;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CW'(XW - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/rational_duration_to_ticks_core.sv
// ----------------------------------------------------------------------------
// rational_duration_to_ticks_core
// Converts a fractional duration plus signed extra ticks into whole ticks,
// carrying the exact fractional rest from item to item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries length_num, length_den
//   and extra_ticks; a transfer happens when valid is high and stall is low.
//   Output channel (o_out_valid / i_out_stall) carries ticks and overflow,
//   one result per input transfer, from a result register.
//   The APB port holds ticks_per_unit at byte address 0; write it only while
//   the core is idle. pready is always high.
// Sequence:
//   One item at a time. From its transfer to its result an item passes
//   through a 31-step quotient, a 16-step bit-serial product, a binary gcd
//   of G steps (G at most 2*(REMAINDER_WIDTH+16)), and a
//   (REMAINDER_WIDTH+16)-step reduction division in the shared divider.
//   A zero denominator goes straight from the transfer to the result.
//   The next item may be taken while a result still waits in the register.
// Reset: synchronous, active low; clears the remainder to 0/1, sets
//   ticks_per_unit to 480 and empties the result register.
// Stall: a stalled result holds; a finished item waits for the register.
// ----------------------------------------------------------------------------
module rational_duration_to_ticks_core #(
    parameter int REMAINDER_WIDTH = rdt_pkg::REM_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rdt_pkg::LEN_W-1:0]    i_length_num,
    input  logic [rdt_pkg::LEN_W-1:0]    i_length_den,
    input  logic [rdt_pkg::EXTRA_W-1:0]  i_extra_ticks,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rdt_pkg::TICKS_W-1:0]  o_ticks,
    output logic                         o_overflow,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rdt_pkg::PADDR_W-1:0]  paddr,
    input  logic [rdt_pkg::PDATA_W-1:0]  pwdata,
    output logic [rdt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import rdt_pkg::*;

    logic [TPU_W-1:0]     r_tpu;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_wr;
    t_cmd                 w_cmd;
    t_status              w_status;

    // Register file: a single word, everything else reads zero and drops writes
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= TPU_RESET;
        end else if (w_wr && (w_reg_idx == REG_TICKS_PER_UNIT)) begin
            r_tpu <= pwdata[TPU_W-1:0];
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_TICKS_PER_UNIT: prdata = {{(PDATA_W-TPU_W){1'b0}}, r_tpu};
            default:            prdata = '0;
        endcase
    end

    // Sequencer: owns both handshakes and steps the datapath
    rdt_ctrl #(.REM_W(REMAINDER_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Arithmetic, remainder state and result payload
    rdt_datapath #(.REM_W(REMAINDER_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_tpu         (r_tpu),
        .i_length_num  (i_length_num),
        .i_length_den  (i_length_den),
        .i_extra_ticks (i_extra_ticks),
        .o_ticks       (o_ticks),
        .o_overflow    (o_overflow)
    );

endmodule

>>> hw/rtl/rdt_checker.sv
// ----------------------------------------------------------------------------
// rdt_checker
// Port-level checks for the rational duration to ticks core, bound to it.
// ----------------------------------------------------------------------------
module rdt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [rdt_pkg::TICKS_W-1:0] o_ticks,
    input logic                        o_overflow
);
    import rdt_pkg::*;

    // Reset empties the result register and opens the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("core not idle after reset");

    // One item at a time: the input closes right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open in the cycle after a transfer");

    // Result never goes below -32768
    a_ticks_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_ticks[TICKS_W-1] || (o_ticks[TICKS_W-2:15] == '1)))
        else $error("ticks below lower bound");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_ticks) && $stable(o_overflow)))
        else $error("stalled result changed");

endmodule

bind rational_duration_to_ticks_core rdt_checker u_rdt_checker (.*);
